// ===== design/pid_conditional_antiwindup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker of the PID controller
// Each macro expands to one labeled concurrent assertion with an async reset.
// ----------------------------------------------------------------------------
`ifndef PID_CONDITIONAL_ANTIWINDUP_ASSERT_SVH
`define PID_CONDITIONAL_ANTIWINDUP_ASSERT_SVH

// Same-cycle implication: cons must hold whenever pre holds.
`define PCA_ASSERT_NOW(lbl, clk, rst_n, pre, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold on the clock after pre holds.
`define PCA_ASSERT_NEXT(lbl, clk, rst_n, pre, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Widths, codes and helpers of the conditional anti-windup PID controller.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int DATA_WIDTH = 16;          // drive, target and sample width
  localparam int GAIN_W     = 32;          // Q16.16 gains
  localparam int STEP_W     = 16;          // Q0.16 sample period
  localparam int LIM_W      = 31;          // integral clamp magnitude
  localparam int ERR_W      = DATA_WIDTH + 1;
  localparam int PROD_W     = 2 * GAIN_W;  // shared multiplier result
  localparam int SUM_W      = 52;          // signed Q.16 sums of P, I and D
  localparam int MAG_W      = SUM_W - 1;
  localparam int INT_W      = 32;          // stored integral, signed Q16.16
  localparam int INT_SUM_W  = 34;          // integral plus one increment
  localparam int QUOT_W     = 49;          // derivative quotient bits
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [QUOT_W-1:0] D_SAT = {1'b1, {(QUOT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP             = 3'd0,
    CFG_KI             = 3'd1,
    CFG_KD             = 3'd2,
    CFG_STEP_TIME      = 3'd3,
    CFG_OUT_LOW        = 3'd4,
    CFG_OUT_HIGH       = 3'd5,
    CFG_INTEGRAL_LIMIT = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  // Turn a magnitude and a sign into a signed term.
  function automatic logic signed [SUM_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                        input logic neg);
    logic signed [SUM_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

endpackage

// ===== design/pca_if.sv =====
// ----------------------------------------------------------------------------
// pca_if
// Valid/ready channels of the PID controller: configuration, step, result.
// ----------------------------------------------------------------------------
interface pca_cfg_if
  import pca_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface pca_in_if
  import pca_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [DATA_WIDTH-1:0] target;
  logic signed [DATA_WIDTH-1:0] sample;

  modport source (output valid, opcode, target, sample, input ready);
  modport sink   (input valid, opcode, target, sample, output ready);
endinterface

interface pca_out_if
  import pca_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         saturated;
  logic                         integral_frozen;

  modport source (output valid, drive, saturated, integral_frozen, input ready);
  modport sink   (input valid, drive, saturated, integral_frozen, output ready);
endinterface

// ===== design/pid_conditional_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_conditional_antiwindup
// Positional PID step with conditional-integration anti-windup. Each beat on
// in_i is a control step (target, sample) or a clear; each returns one beat on
// out_o with the clamped drive and two flags. Gains are unsigned Q16.16, the
// sample period is Q0.16 and the integral is signed Q16.16, clamped to
// +-integral_limit. Derivative acts on the measurement and is on only for a
// nonzero kd. All products go through one shared 32x32 multiplier under a
// one-hot sequencer; the derivative division by the sample period runs in a
// restoring divider that retires one quotient bit per cycle. A control step
// runs through the multiply states, and also through the divider states when
// the derivative needs a real division (kd nonzero, measurement changed,
// period nonzero and quotient below the 2^49 bound); a clear goes straight to
// the result register. in_i is not ready while a step is in flight; the
// result register lets the next beat in while the last result still waits.
// Configuration writes are taken every cycle and belong only between steps.
// ----------------------------------------------------------------------------
module pid_conditional_antiwindup
  import pca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pca_cfg_if.sink    cfg_i,
  pca_in_if.sink     in_i,
  pca_out_if.source  out_o
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'h0001,
    S_MUL_P     = 15'h0002,  // kp * |err|
    S_MUL_D     = 15'h0004,  // kd * |diff|, store P
    S_DIV_START = 15'h0008,  // pick zero, saturated or divided D
    S_DIV       = 15'h0010,  // one quotient bit per cycle
    S_DIV_DONE  = 15'h0020,
    S_MUL_I     = 15'h0040,  // ki * |integral|, form P + D
    S_MUL_E     = 15'h0080,  // |err| * step_time, store I
    S_RAW       = 15'h0100,  // raw output
    S_FREEZE    = 15'h0200,  // anti-windup decision and accumulate
    S_CLAMP_I   = 15'h0400,
    S_MUL_I2    = 15'h0800,  // ki * |new integral|
    S_TERM_I2   = 15'h1000,
    S_SUM       = 15'h2000,
    S_OUT       = 15'h4000   // clamp and load the result register
  } state_e;

  // Configuration registers.
  logic        [GAIN_W-1:0]     kp_q, ki_q, kd_q;
  logic        [STEP_W-1:0]     step_q;
  logic signed [DATA_WIDTH-1:0] out_low_q, out_high_q;
  logic        [LIM_W-1:0]      lim_q;

  // Control and controller state.
  state_e                       state_q, state_d;
  logic signed [INT_W-1:0]      integ_q, integ_d;
  logic signed [DATA_WIDTH-1:0] last_q, last_d;
  logic                         clr_q, clr_d;
  logic                         out_valid_q, out_valid_d;

  // Datapath.
  logic signed [ERR_W-1:0]      err_q, err_d, diff_q, diff_d;
  logic signed [DATA_WIDTH-1:0] smp_q, smp_d;
  logic        [PROD_W-1:0]     prod_q, prod_d;
  logic signed [SUM_W-1:0]      p_q, p_d, d_q, d_d, pd_q, pd_d, i_q, i_d, raw_q, raw_d;
  logic signed [INT_SUM_W-1:0]  es_q, es_d, isum_q, isum_d;
  logic                         frozen_q, frozen_d;
  logic        [STEP_W-1:0]     rem_q, rem_d;
  logic        [QUOT_W-1:0]     num_q, num_d, quot_q, quot_d;
  logic        [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic signed [DATA_WIDTH-1:0] drive_q, drive_d;
  logic                         sat_q, sat_d, frz_out_q, frz_out_d;

  // Shared multiplier.
  logic [GAIN_W-1:0] mul_a, mul_b;
  logic              mul_en;

  logic                         in_acc, out_free;
  logic        [ERR_W-1:0]      err_mag, diff_mag;
  logic        [INT_W-1:0]      integ_mag;
  logic                         err_neg, err_pos, diff_neg;
  logic signed [SUM_W-1:0]      hi_w, lo_w, o_clamp;
  logic                         o_sat;
  logic        [STEP_W:0]       div_part;
  logic                         div_take;
  logic        [QUOT_W-1:0]     d_mag;
  logic signed [INT_SUM_W-1:0]  lim_w, es_c;
  logic        [PROD_W-1:0]     a_num;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign out_o.valid           = out_valid_q;
  assign out_o.drive           = drive_q;
  assign out_o.saturated       = sat_q;
  assign out_o.integral_frozen = frz_out_q;

  assign err_neg   = err_q[ERR_W-1];
  assign err_pos   = !err_neg && (err_q != '0);
  assign diff_neg  = diff_q[ERR_W-1];
  assign err_mag   = err_neg ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign diff_mag  = diff_neg ? ERR_W'(-diff_q) : ERR_W'(diff_q);
  assign integ_mag = integ_q[INT_W-1] ? INT_W'(-integ_q) : INT_W'(integ_q);

  // Output limits in Q.16; they are whole numbers, so an arithmetic shift
  // of a clamped value is its floor and stays inside them.
  assign hi_w  = $signed({{(SUM_W-DATA_WIDTH-16){out_high_q[DATA_WIDTH-1]}},
                          out_high_q, 16'b0});
  assign lo_w  = $signed({{(SUM_W-DATA_WIDTH-16){out_low_q[DATA_WIDTH-1]}},
                          out_low_q, 16'b0});
  assign lim_w = $signed({{(INT_SUM_W-LIM_W){1'b0}}, lim_q});

  // kd * |diff| lies below 2^48.
  assign a_num = prod_q;

  // Restoring divider step: bring down the next numerator bit.
  assign div_part = {rem_q, num_q[QUOT_W-1]};
  assign div_take = (div_part >= {1'b0, step_q});

  assign d_mag = (quot_q > D_SAT) ? D_SAT : quot_q;

  assign es_c = err_neg ? -$signed({1'b0, prod_q[INT_SUM_W-2:0]})
                        : $signed({1'b0, prod_q[INT_SUM_W-2:0]});

  // Upper clamp first, then lower: inverted limits leave out_low.
  always_comb begin
    o_clamp = raw_q;
    o_sat   = 1'b0;
    if (raw_q > hi_w) begin
      o_clamp = hi_w;
      o_sat   = 1'b1;
    end
    if (o_clamp < lo_w) begin
      o_clamp = lo_w;
      o_sat   = 1'b1;
    end
  end

  // Operand select of the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state_q)
      S_MUL_P: begin
        mul_a  = kp_q;
        mul_b  = GAIN_W'(err_mag);
        mul_en = 1'b1;
      end
      S_MUL_D: begin
        mul_a  = kd_q;
        mul_b  = GAIN_W'(diff_mag);
        mul_en = 1'b1;
      end
      S_MUL_I, S_MUL_I2: begin
        mul_a  = ki_q;
        mul_b  = integ_mag;
        mul_en = 1'b1;
      end
      S_MUL_E: begin
        mul_a  = GAIN_W'(step_q);
        mul_b  = GAIN_W'(err_mag);
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod_d = mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : prod_q;

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    integ_d     = integ_q;
    last_d      = last_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    err_d       = err_q;
    diff_d      = diff_q;
    smp_d       = smp_q;
    p_d         = p_q;
    d_d         = d_q;
    pd_d        = pd_q;
    i_d         = i_q;
    raw_d       = raw_q;
    es_d        = es_q;
    isum_d      = isum_q;
    frozen_d    = frozen_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    drive_d     = drive_q;
    sat_d       = sat_q;
    frz_out_d   = frz_out_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OP_CLEAR) begin
            integ_d = '0;
            last_d  = '0;
            clr_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            clr_d   = 1'b0;
            err_d   = ERR_W'(in_i.target) - ERR_W'(in_i.sample);
            diff_d  = ERR_W'(last_q) - ERR_W'(in_i.sample);
            smp_d   = in_i.sample;
            state_d = S_MUL_P;
          end
        end
      end
      S_MUL_P: begin
        state_d = S_MUL_D;
      end
      S_MUL_D: begin
        p_d     = apply_sign(MAG_W'(prod_q[47:0]), err_neg);
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        state_d = S_MUL_I;
        if (kd_q != '0) begin
          last_d = smp_q;
        end
        if (kd_q == '0 || a_num == '0) begin
          d_d = '0;
        end else if (step_q == '0 || {1'b0, a_num[47:33]} >= step_q) begin
          // Quotient at or above 2^49: saturate.
          d_d = apply_sign(MAG_W'(D_SAT), diff_neg);
        end else begin
          rem_d   = STEP_W'(a_num[47:33]);
          num_d   = {a_num[32:0], 16'b0};
          quot_d  = '0;
          cnt_d   = DIV_CNT_W'(QUOT_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = div_take ? STEP_W'(div_part - {1'b0, step_q}) : div_part[STEP_W-1:0];
        num_d  = {num_q[QUOT_W-2:0], 1'b0};
        quot_d = {quot_q[QUOT_W-2:0], div_take};
        cnt_d  = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_DIV_DONE;
        end
      end
      S_DIV_DONE: begin
        d_d     = apply_sign(MAG_W'(d_mag), diff_neg);
        state_d = S_MUL_I;
      end
      S_MUL_I: begin
        pd_d    = p_q + d_q;
        state_d = S_MUL_E;
      end
      S_MUL_E: begin
        i_d     = apply_sign(MAG_W'(prod_q[PROD_W-1:16]), integ_q[INT_W-1]);
        state_d = S_RAW;
      end
      S_RAW: begin
        raw_d   = pd_q + i_q;
        es_d    = es_c;
        state_d = S_FREEZE;
      end
      S_FREEZE: begin
        // Hold the integral while the output sits at a limit and the error
        // pushes further into it.
        frozen_d = ((raw_q >= hi_w) && err_pos) || ((raw_q <= lo_w) && err_neg);
        isum_d   = $signed({{(INT_SUM_W-INT_W){integ_q[INT_W-1]}}, integ_q})
                 + (frozen_d ? '0 : es_q);
        state_d  = S_CLAMP_I;
      end
      S_CLAMP_I: begin
        if (isum_q > lim_w) begin
          integ_d = INT_W'(lim_w);
        end else if (isum_q < -lim_w) begin
          integ_d = INT_W'(-lim_w);
        end else begin
          integ_d = INT_W'(isum_q);
        end
        state_d = S_MUL_I2;
      end
      S_MUL_I2: begin
        state_d = S_TERM_I2;
      end
      S_TERM_I2: begin
        i_d     = apply_sign(MAG_W'(prod_q[PROD_W-1:16]), integ_q[INT_W-1]);
        state_d = S_SUM;
      end
      S_SUM: begin
        raw_d   = pd_q + i_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Wait for the result register to drain.
        if (out_free) begin
          out_valid_d = 1'b1;
          if (clr_q) begin
            drive_d   = '0;
            sat_d     = 1'b0;
            frz_out_d = 1'b0;
          end else begin
            drive_d   = o_clamp[DATA_WIDTH+15:16];
            sat_d     = o_sat;
            frz_out_d = frozen_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      step_q     <= STEP_W'(656);
      out_low_q  <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      out_high_q <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      lim_q      <= '1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_KP:             kp_q       <= cfg_i.data;
        CFG_KI:             ki_q       <= cfg_i.data;
        CFG_KD:             kd_q       <= cfg_i.data;
        CFG_STEP_TIME:      step_q     <= cfg_i.data[STEP_W-1:0];
        CFG_OUT_LOW:        out_low_q  <= $signed(cfg_i.data[DATA_WIDTH-1:0]);
        CFG_OUT_HIGH:       out_high_q <= $signed(cfg_i.data[DATA_WIDTH-1:0]);
        CFG_INTEGRAL_LIMIT: lim_q      <= cfg_i.data[LIM_W-1:0];
        default: begin
          // Drop writes to unmapped indexes.
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      integ_q     <= '0;
      last_q      <= '0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      integ_q     <= integ_d;
      last_q      <= last_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    diff_q    <= diff_d;
    smp_q     <= smp_d;
    prod_q    <= prod_d;
    p_q       <= p_d;
    d_q       <= d_d;
    pd_q      <= pd_d;
    i_q       <= i_d;
    raw_q     <= raw_d;
    es_q      <= es_d;
    isum_q    <= isum_d;
    frozen_q  <= frozen_d;
    rem_q     <= rem_d;
    num_q     <= num_d;
    quot_q    <= quot_d;
    cnt_q     <= cnt_d;
    drive_q   <= drive_d;
    sat_q     <= sat_d;
    frz_out_q <= frz_out_d;
  end

endmodule

// ===== design/pca_checker.sv =====
// ----------------------------------------------------------------------------
// pca_checker
// Port-level checks of the PID controller, bound to its top level.
// ----------------------------------------------------------------------------
module pca_checker
  import pca_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_opcode_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] out_drive_i,
  input logic                         out_saturated_i,
  input logic                         out_integral_frozen_i
);

`include "pid_conditional_antiwindup_assert.svh"

  logic in_beat;
  logic out_stall;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result beat holds.
  `PCA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_drive_i) && $stable(out_saturated_i) && $stable(out_integral_frozen_i), "result beat changed while stalled")

  // One step at a time: the input closes right after a beat.
  `PCA_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat, !in_ready_i, "input ready right after an accepted beat")

  // A new result only appears from a step in flight.
  `PCA_ASSERT_NOW(a_result_from_step, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i), "result appeared while idle")

  // A clear into a free output returns an all-zero result via S_OUT and the result register.
  `PCA_ASSERT_NEXT(a_clear_zero, clk_i, rst_ni, in_beat && (in_opcode_i == OP_CLEAR) && !out_valid_i, ##1 (out_valid_i && (out_drive_i == '0) && !out_saturated_i && !out_integral_frozen_i), "clear did not give a zero result")

endmodule

bind pid_conditional_antiwindup pca_checker u_pca_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .in_opcode_i           (in_i.opcode),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_drive_i           (out_o.drive),
  .out_saturated_i       (out_o.saturated),
  .out_integral_frozen_i (out_o.integral_frozen)
);
